// ===== rtl/crip_pkg.sv =====
// Shared constants, field widths and the activation clip function for the incremental pool.
package crip_pkg;

  // Field widths of one transfer
  localparam int SRC_W    = 8;
  localparam int ELEM_W   = 5;
  localparam int ACC_W    = 32;
  localparam int RSEL_W   = 4;
  localparam int ACT_W    = 9;
  localparam int CHG_W    = 10;

  // Fixed-point constants of the activation
  localparam int FRAC_BITS      = 10;
  localparam int HALF_MINUS_ONE = 511;
  localparam int ACT_MAX        = 256;

  // Default geometry
  localparam int WIDTH_DEF   = 32;
  localparam int SOURCES_DEF = 256;
  localparam int REGIONS_DEF = 16;

  // Address bits for a store of the given depth, never below one
  function automatic int addr_bits(input int depth);
    int bits;
    bits = (depth > 1) ? $clog2(depth) : 1;
    return bits;
  endfunction

  // Divide by 2^FRAC_BITS rounding half to even, then clamp to 0..ACT_MAX
  function automatic logic [ACT_W-1:0] clip_act(input logic signed [ACC_W-1:0] raw);
    logic signed [ACC_W:0]     rsum;
    logic [ACC_W-FRAC_BITS:0]  quot;
    logic [ACT_W-1:0]          res;
    rsum = $signed({raw[ACC_W-1], raw})
         + $signed({1'b0, ACC_W'(HALF_MINUS_ONE)})
         + $signed({{ACC_W{1'b0}}, raw[FRAC_BITS]});
    quot = rsum[ACC_W:FRAC_BITS];
    if (quot[ACC_W-FRAC_BITS]) begin
      res = '0;
    end else if (quot > (ACC_W-FRAC_BITS+1)'(ACT_MAX)) begin
      res = ACT_W'(ACT_MAX);
    end else begin
      res = quot[ACT_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/crip_in_if.sv =====
// Input channel: one accumulator update per transfer.
interface crip_in_if;
  import crip_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [SRC_W-1:0]        source;
  logic [ELEM_W-1:0]       element;
  logic signed [ACC_W-1:0] accum_value;
  logic [RSEL_W-1:0]       region_sel;

  modport src (output valid, source, element, accum_value, region_sel, input ready);
  modport sink (input valid, source, element, accum_value, region_sel, output ready);
endinterface

// ===== rtl/crip_out_if.sv =====
// Output channel: new activation, its change and the updated pool totals per transfer.
interface crip_out_if;
  import crip_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        activation;
  logic signed [CHG_W-1:0] change;
  logic signed [ACC_W-1:0] global_total;
  logic signed [ACC_W-1:0] region_total;

  modport src (output valid, activation, change, global_total, region_total, input ready);
  modport sink (input valid, activation, change, global_total, region_total, output ready);
endinterface

// ===== rtl/crip_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module crip_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/crip_clear.sv =====
// Post-reset sweep counter that walks every store address once.
module crip_clear #(
  parameter int CLR_LEN = 8192,
  localparam int CW = crip_pkg::addr_bits(CLR_LEN)
) (
  input  logic          clk,
  input  logic          rst,
  output logic          busy,
  output logic [CW-1:0] addr
);
  import crip_pkg::*;

  localparam logic [CW-1:0] LAST = CW'(CLR_LEN - 1);

  // Advance one address per cycle until the last one is written
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      addr <= '0;
    end else if (busy) begin
      if (addr == LAST) begin
        busy <= 1'b0;
      end else begin
        addr <= addr + 1'b1;
      end
    end
  end

  a_sweep_ends: assert property (@(posedge clk) disable iff (rst)
    busy && addr == LAST |=> !busy)
    else $error("clear sweep did not end at the last address");

  a_sweep_once: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !busy)
    else $error("clear sweep restarted without reset");

endmodule

// ===== rtl/clipped_relu_incremental_pool_core.sv =====
// Clipped-ReLU activation update with incremental global and per-region pooling.
// Each accepted transfer carries a scaled accumulator value for one element of one source;
// the block rounds it (divide by 1024, half to even), clamps it to 0..256, subtracts the
// activation stored for that source and element, and adds the change to the element's global
// pool entry and to the selected region's entry, both wrapping at 32 bits. The three stores
// are synchronous RAMs read at acceptance and written back as the item leaves the update stage;
// a write and a read of the same entry in one cycle are resolved by forwarding, so one transfer
// is taken per cycle while the output register drains. Apart from the clear sweep, the input
// side stalls only when the single result register is full and not taken. After reset the
// block sweeps all stores to zero before it raises ready. Source, element and region indexes
// are reduced modulo SOURCES, WIDTH and REGIONS.
module clipped_relu_incremental_pool_core #(
  parameter int WIDTH   = crip_pkg::WIDTH_DEF,
  parameter int SOURCES = crip_pkg::SOURCES_DEF,
  parameter int REGIONS = crip_pkg::REGIONS_DEF
) (
  input logic     clk,
  input logic     rst,
  crip_in_if.sink sample,
  crip_out_if.src result
);
  import crip_pkg::*;

  localparam int SW        = addr_bits(SOURCES);
  localparam int EW        = addr_bits(WIDTH);
  localparam int RW        = addr_bits(REGIONS);
  localparam int ACT_DEPTH = SOURCES * WIDTH;
  localparam int REG_DEPTH = REGIONS * WIDTH;
  localparam int ACT_AW    = addr_bits(ACT_DEPTH);
  localparam int REG_AW    = addr_bits(REG_DEPTH);
  localparam int CLR_LEN   = (ACT_DEPTH > REG_DEPTH) ? ACT_DEPTH : REG_DEPTH;
  localparam int CLR_W     = addr_bits(CLR_LEN);

  // Index reduction tables
  logic [SW-1:0] src_map  [2**SRC_W];
  logic [EW-1:0] elem_map [2**ELEM_W];
  logic [RW-1:0] rsel_map [2**RSEL_W];

  for (genvar i = 0; i < 2**SRC_W; i++) begin : g_src_map
    assign src_map[i] = SW'(i % SOURCES);
  end
  for (genvar i = 0; i < 2**ELEM_W; i++) begin : g_elem_map
    assign elem_map[i] = EW'(i % WIDTH);
  end
  for (genvar i = 0; i < 2**RSEL_W; i++) begin : g_rsel_map
    assign rsel_map[i] = RW'(i % REGIONS);
  end

  // Clear sweep
  logic             clr_busy;
  logic [CLR_W-1:0] clr_addr;
  logic             clr_act_en;
  logic             clr_glb_en;
  logic             clr_reg_en;

  crip_clear #(.CLR_LEN(CLR_LEN)) u_clear (
    .clk  (clk),
    .rst  (rst),
    .busy (clr_busy),
    .addr (clr_addr)
  );

  assign clr_act_en = clr_busy && ({1'b0, clr_addr} < (CLR_W+1)'(ACT_DEPTH));
  assign clr_glb_en = clr_busy && ({1'b0, clr_addr} < (CLR_W+1)'(WIDTH));
  assign clr_reg_en = clr_busy && ({1'b0, clr_addr} < (CLR_W+1)'(REG_DEPTH));

  // Accept stage: decode addresses, compute the clipped activation, issue reads
  logic              accept;
  logic              s1_fire;
  logic [SW-1:0]     src_idx;
  logic [EW-1:0]     elem_idx;
  logic [RW-1:0]     rsel_idx;
  logic [ACT_AW-1:0] act_raddr;
  logic [REG_AW-1:0] reg_raddr;
  logic [ACT_W-1:0]  act_in;

  assign accept    = sample.valid && sample.ready;
  assign src_idx   = src_map[sample.source];
  assign elem_idx  = elem_map[sample.element];
  assign rsel_idx  = rsel_map[sample.region_sel];
  assign act_raddr = ACT_AW'(src_idx) * ACT_AW'(WIDTH) + ACT_AW'(elem_idx);
  assign reg_raddr = REG_AW'(rsel_idx) * REG_AW'(WIDTH) + REG_AW'(elem_idx);
  assign act_in    = clip_act(sample.accum_value);

  // Update stage registers
  logic              s1_valid;
  logic [ACT_W-1:0]  s1_act;
  logic [ACT_AW-1:0] s1_act_addr;
  logic [EW-1:0]     s1_glb_addr;
  logic [REG_AW-1:0] s1_reg_addr;
  logic              fw_act;
  logic              fw_glb;
  logic              fw_reg;
  logic [ACT_W-1:0]  fw_act_data;
  logic [ACC_W-1:0]  fw_glb_data;
  logic [ACC_W-1:0]  fw_reg_data;

  // RAM read data and write controls
  logic [ACT_W-1:0]  act_rdata;
  logic [ACC_W-1:0]  glb_rdata;
  logic [ACC_W-1:0]  reg_rdata;
  logic              act_we;
  logic              glb_we;
  logic              reg_we;
  logic [ACT_AW-1:0] act_waddr;
  logic [EW-1:0]     glb_waddr;
  logic [REG_AW-1:0] reg_waddr;
  logic [ACT_W-1:0]  act_wdata;
  logic [ACC_W-1:0]  glb_wdata;
  logic [ACC_W-1:0]  reg_wdata;

  // Update stage arithmetic
  logic [ACT_W-1:0]        prev_act;
  logic [ACC_W-1:0]        glb_old;
  logic [ACC_W-1:0]        reg_old;
  logic signed [CHG_W-1:0] delta;
  logic [ACC_W-1:0]        delta_ext;
  logic [ACC_W-1:0]        glb_new;
  logic [ACC_W-1:0]        reg_new;

  // Output register
  logic                    out_valid;
  logic [ACT_W-1:0]        out_act;
  logic signed [CHG_W-1:0] out_chg;
  logic [ACC_W-1:0]        out_glb;
  logic [ACC_W-1:0]        out_reg;

  assign s1_fire      = s1_valid && (!out_valid || result.ready);
  assign sample.ready = !clr_busy && (!s1_valid || s1_fire);

  // Take forwarded values where the previous item wrote the same entry
  assign prev_act  = fw_act ? fw_act_data : act_rdata;
  assign glb_old   = fw_glb ? fw_glb_data : glb_rdata;
  assign reg_old   = fw_reg ? fw_reg_data : reg_rdata;
  assign delta     = $signed({1'b0, s1_act} - {1'b0, prev_act});
  assign delta_ext = {{(ACC_W-CHG_W){delta[CHG_W-1]}}, delta};
  assign glb_new   = glb_old + delta_ext;
  assign reg_new   = reg_old + delta_ext;

  // Update stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture the accepted item and any same-cycle write to its entries
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_act      <= act_in;
      s1_act_addr <= act_raddr;
      s1_glb_addr <= elem_idx;
      s1_reg_addr <= reg_raddr;
      fw_act      <= s1_fire && (act_raddr == s1_act_addr);
      fw_glb      <= s1_fire && (elem_idx == s1_glb_addr);
      fw_reg      <= s1_fire && (reg_raddr == s1_reg_addr);
      fw_act_data <= s1_act;
      fw_glb_data <= glb_new;
      fw_reg_data <= reg_new;
    end
  end

  // Write back on completion, or zero during the sweep
  assign act_we    = clr_busy ? clr_act_en : s1_fire;
  assign glb_we    = clr_busy ? clr_glb_en : s1_fire;
  assign reg_we    = clr_busy ? clr_reg_en : s1_fire;
  assign act_waddr = clr_busy ? clr_addr[ACT_AW-1:0] : s1_act_addr;
  assign glb_waddr = clr_busy ? clr_addr[EW-1:0] : s1_glb_addr;
  assign reg_waddr = clr_busy ? clr_addr[REG_AW-1:0] : s1_reg_addr;
  assign act_wdata = clr_busy ? '0 : s1_act;
  assign glb_wdata = clr_busy ? '0 : glb_new;
  assign reg_wdata = clr_busy ? '0 : reg_new;

  crip_ram #(.DATA_W(ACT_W), .DEPTH(ACT_DEPTH)) u_act_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (act_waddr),
    .wdata (act_wdata),
    .re    (accept),
    .raddr (act_raddr),
    .rdata (act_rdata)
  );

  crip_ram #(.DATA_W(ACC_W), .DEPTH(WIDTH)) u_glb_ram (
    .clk   (clk),
    .we    (glb_we),
    .waddr (glb_waddr),
    .wdata (glb_wdata),
    .re    (accept),
    .raddr (elem_idx),
    .rdata (glb_rdata)
  );

  crip_ram #(.DATA_W(ACC_W), .DEPTH(REG_DEPTH)) u_reg_ram (
    .clk   (clk),
    .we    (reg_we),
    .waddr (reg_waddr),
    .wdata (reg_wdata),
    .re    (accept),
    .raddr (reg_raddr),
    .rdata (reg_rdata)
  );

  // Output register: load on completion, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_act <= s1_act;
      out_chg <= delta;
      out_glb <= glb_new;
      out_reg <= reg_new;
    end
  end

  assign result.valid        = out_valid;
  assign result.activation   = out_act;
  assign result.change       = out_chg;
  assign result.global_total = out_glb;
  assign result.region_total = out_reg;

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result.valid && !sample.ready)
    else $error("output valid or input ready right after reset");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !sample.ready)
    else $error("input ready during clear sweep");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid)
    else $error("stalled update stage lost its item");

  a_act_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.activation <= ACT_W'(ACT_MAX))
    else $error("activation above clamp limit");

endmodule

// ===== verif/tb_clipped_relu_incremental_pool_core.sv =====
// Testbench for the clipped-ReLU incremental pool core: random and directed updates, checked result by result.
`timescale 1ns / 1ps

module tb_clipped_relu_incremental_pool_core;
  import crip_pkg::*;

  localparam int N_RANDOM = 1100;

  typedef struct packed {
    logic [SRC_W-1:0]        src;
    logic [ELEM_W-1:0]       elem;
    logic signed [ACC_W-1:0] acc;
    logic [RSEL_W-1:0]       rsel;
  } update_t;

  typedef struct packed {
    logic [ACT_W-1:0]        activation;
    logic signed [CHG_W-1:0] change;
    logic signed [ACC_W-1:0] global_total;
    logic signed [ACC_W-1:0] region_total;
  } pool_result_t;

  // Mirror of the activation and pool stores, plus the results still owed by the block
  class activation_pool_tracker;
    logic [ACT_W-1:0]        stored_act [SOURCES_DEF*WIDTH_DEF];
    logic signed [ACC_W-1:0] element_pool [WIDTH_DEF];
    logic signed [ACC_W-1:0] region_pool [REGIONS_DEF*WIDTH_DEF];
    pool_result_t            pending [$];
    int errors, updates, checked, ties, clipped_high, clipped_low;

    function new();
      foreach (stored_act[i]) stored_act[i] = '0;
      foreach (element_pool[i]) element_pool[i] = '0;
      foreach (region_pool[i]) region_pool[i] = '0;
      errors = 0;
      updates = 0;
      checked = 0;
      ties = 0;
      clipped_high = 0;
      clipped_low = 0;
    endfunction

    // Floor-divide by 1024, bump on remainders above half or on an odd tie, then clamp
    function logic [ACT_W-1:0] round_and_clip(logic signed [ACC_W-1:0] acc);
      longint scaled, whole, frac, q;
      scaled = acc;
      whole = scaled >>> FRAC_BITS;
      frac = scaled & ((64'd1 << FRAC_BITS) - 1);
      q = whole;
      if (frac == (1 << (FRAC_BITS - 1))) begin
        ties++;
        if ((whole & 1) != 0) q = whole + 1;
      end else if (frac > (1 << (FRAC_BITS - 1))) begin
        q = whole + 1;
      end
      if (q < 0) begin
        clipped_low++;
        return '0;
      end
      if (q > ACT_MAX) begin
        clipped_high++;
        return ACT_W'(ACT_MAX);
      end
      return ACT_W'(q);
    endfunction

    // Apply one accepted update and queue the result it must produce
    function void note_update(update_t u);
      int a_idx, e_idx, r_idx, delta;
      logic [ACT_W-1:0] next_act;
      pool_result_t r;
      e_idx = int'(u.elem) % WIDTH_DEF;
      a_idx = (int'(u.src) % SOURCES_DEF) * WIDTH_DEF + e_idx;
      r_idx = (int'(u.rsel) % REGIONS_DEF) * WIDTH_DEF + e_idx;
      next_act = round_and_clip(u.acc);
      delta = int'(next_act) - int'(stored_act[a_idx]);
      element_pool[e_idx] = element_pool[e_idx] + ACC_W'(delta);
      region_pool[r_idx] = region_pool[r_idx] + ACC_W'(delta);
      stored_act[a_idx] = next_act;
      r.activation = next_act;
      r.change = CHG_W'(delta);
      r.global_total = element_pool[e_idx];
      r.region_total = region_pool[r_idx];
      pending.push_back(r);
      updates++;
    endfunction

    // Compare one result transfer with the oldest owed result
    function void check_result(pool_result_t got);
      pool_result_t want;
      if (pending.size() == 0) begin
        $error("result with nothing owed: activation %0d change %0d", got.activation, got.change);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.activation !== want.activation) begin
        $error("activation: expected %0d, got %0d", want.activation, got.activation);
        errors++;
      end
      if (got.change !== want.change) begin
        $error("change: expected %0d, got %0d", want.change, got.change);
        errors++;
      end
      if (got.global_total !== want.global_total) begin
        $error("global_total: expected %0d, got %0d", want.global_total, got.global_total);
        errors++;
      end
      if (got.region_total !== want.region_total) begin
        $error("region_total: expected %0d, got %0d", want.region_total, got.region_total);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm = 1'b0;

  crip_in_if  sample_ch();
  crip_out_if result_ch();

  activation_pool_tracker tracker = new();

  clipped_relu_incremental_pool_core uut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch)
  );

  always #5 clk = ~clk;

  // Give up if the run hangs
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic update_t mk_update(int src, int elem, logic signed [ACC_W-1:0] acc, int rsel);
    update_t u;
    u.src = SRC_W'(src);
    u.elem = ELEM_W'(elem);
    u.acc = acc;
    u.rsel = RSEL_W'(rsel);
    return u;
  endfunction

  // Random update biased toward hot entries, tie remainders and the clamp edges
  function automatic update_t random_update();
    update_t u;
    int k;
    u.src = ($urandom_range(99) < 60) ? SRC_W'($urandom_range(3)) : SRC_W'($urandom_range(255));
    u.elem = ($urandom_range(99) < 50) ? ELEM_W'($urandom_range(1)) : ELEM_W'($urandom_range(31));
    u.rsel = ($urandom_range(99) < 30) ? RSEL_W'($urandom_range(1)) : RSEL_W'($urandom_range(15));
    k = int'($urandom_range(264)) - 4;
    case ($urandom_range(9))
      0, 1: u.acc = $urandom;
      2, 3, 8, 9: u.acc = k * 1024 + int'($urandom_range(1023));
      4: u.acc = k * 1024 + 512;
      5: u.acc = k * 1024 + (($urandom_range(1) != 0) ? 511 : 513);
      6: u.acc = -int'($urandom_range(300000));
      default: begin
        case ($urandom_range(4))
          0: u.acc = 32'sh7FFF_FFFF;
          1: u.acc = 32'sh8000_0000;
          2: u.acc = 256 * 1024 + 512;
          3: u.acc = 255 * 1024 + 512;
          default: u.acc = '0;
        endcase
      end
    endcase
    return u;
  endfunction

  // Offer one update, idling first at random, and hold it until the transfer
  task automatic offer_update(update_t u);
    while (!calm && $urandom_range(99) < 27) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.source <= u.src;
    sample_ch.element <= u.elem;
    sample_ch.accum_value <= u.acc;
    sample_ch.region_sel <= u.rsel;
    do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
    tracker.note_update(u);
    @(negedge clk);
  endtask

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      tracker.check_result({result_ch.activation, result_ch.change,
                            result_ch.global_total, result_ch.region_total});
    end
  end

  // Drive ready: random stalls, one long hold-off, none during the calm stretch
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && tracker.checked >= 400) begin
        result_ch.ready <= 1'b0;
        hold_left = 80;
        hold_done = 1'b1;
      end else begin
        result_ch.ready <= calm || ($urandom_range(99) >= 27);
      end
    end
  end

  // Reset, directed updates, random updates, drain and verdict
  initial begin
    update_t directed [$];
    sample_ch.valid = 1'b0;
    sample_ch.source = '0;
    sample_ch.element = '0;
    sample_ch.accum_value = '0;
    sample_ch.region_sel = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Ties, clamp edges, extremes of every field, repeated entries for negative changes
    directed.push_back(mk_update(0, 0, 0, 0));
    directed.push_back(mk_update(255, 31, 512, 15));
    directed.push_back(mk_update(0, 0, 1536, 0));
    directed.push_back(mk_update(0, 0, 1535, 0));
    directed.push_back(mk_update(0, 0, 2560, 1));
    directed.push_back(mk_update(0, 0, 1537, 1));
    directed.push_back(mk_update(1, 5, -512, 3));
    directed.push_back(mk_update(1, 5, -1536, 3));
    directed.push_back(mk_update(2, 31, 262144, 15));
    directed.push_back(mk_update(2, 31, 262144 + 512, 15));
    directed.push_back(mk_update(2, 31, 255 * 1024 + 512, 0));
    directed.push_back(mk_update(2, 31, 254 * 1024 + 512, 0));
    directed.push_back(mk_update(2, 31, 32'sh7FFF_FFFF, 7));
    directed.push_back(mk_update(2, 31, 32'sh8000_0000, 7));
    directed.push_back(mk_update(3, 0, 32'sh7FFF_FFFF, 15));
    directed.push_back(mk_update(3, 0, -1, 15));
    directed.push_back(mk_update(255, 0, 257 * 1024, 0));
    directed.push_back(mk_update(255, 0, 1023, 8));
    directed.push_back(mk_update(128, 16, 100 * 1024 + 511, 4));
    directed.push_back(mk_update(128, 16, 100 * 1024 + 513, 4));
    directed.push_back(mk_update(128, 16, 101 * 1024 + 512, 4));
    directed.push_back(mk_update(128, 16, -1024 * 1000, 4));
    foreach (directed[i]) offer_update(directed[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 600 && n < 800);
      offer_update(random_update());
    end
    calm = 1'b0;
    sample_ch.valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (tracker.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Ran %0d updates and checked %0d results (%0d errors).",
             tracker.updates, tracker.checked, tracker.errors);
    $display("Rounding ties: %0d, clamped high: %0d, clamped low: %0d.",
             tracker.ties, tracker.clipped_high, tracker.clipped_low);
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
